@@ rtl/ppkbd_pkg.sv @@
// Shared constants, codes and types for the parallel port keyboard interface.
package ppkbd_pkg;

    // Key matrix geometry and slow timer width
    localparam int KEY_ROWS      = 10;
    localparam int TIMER_OUT_BIT = 23;
    localparam int TIMER_W       = TIMER_OUT_BIT + 1;
    localparam int ROW_AW        = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

    // Field widths fixed by the bus
    localparam int DATA_W = 8;
    localparam int ROW_W  = 4;

    // Read value for the control register and rows past the matrix
    localparam logic [DATA_W-1:0] ALL_ONES = 8'hFF;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_BUS_READ  = 2'd0,
        REQ_BUS_WRITE = 2'd1,
        REQ_KEY_ROW   = 2'd2,
        REQ_TICK      = 2'd3
    } req_t;

    // Register selects
    typedef enum logic [1:0] {
        SEL_PORT_A  = 2'd0,
        SEL_PORT_B  = 2'd1,
        SEL_PORT_C  = 2'd2,
        SEL_CONTROL = 2'd3
    } port_sel_t;

    // Work carried from acceptance to the stage that sees the key row read data
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              key_read;
        logic              row_ok;
        logic              video_disabled;
        logic              green_led;
    } ppkbd_stage_t;

endpackage

@@ rtl/ppkbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ppkbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, then registered read of the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/parallel_port_keyboard_interface.sv @@
// Top level of the parallel port keyboard interface.
//
// One request is taken every clock cycle while m_ready does not stall the
// output, and each request gives exactly one result. At acceptance the port
// latches and the slow timer are updated and the key row read is issued to
// the key matrix RAM; stage 1 then takes that RAM's registered read data, and
// an output register then presents the result. The registered read of the key
// matrix RAM is why stage 1 exists; while the output is not stalled, the
// rate is one request per cycle. Key row writes land in the RAM at
// acceptance, so a following port B read sees them. Per-row valid bits make
// unwritten rows read as no key pressed, so no clearing pass follows reset.
module parallel_port_keyboard_interface
    import ppkbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [1:0]        s_addr,
    input  logic [DATA_W-1:0] s_wdata,
    input  logic [ROW_W-1:0]  s_key_row,
    input  logic [DATA_W-1:0] s_key_bits,
    input  logic              s_vblank_active,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_rdata,
    output logic              m_video_disabled,
    output logic              m_green_led
);

    logic [DATA_W-1:0]  port_a_reg, port_a_next;
    logic [DATA_W-1:0]  port_c_reg, port_c_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [KEY_ROWS-1:0] key_valid_reg, key_valid_next;

    logic               s1_valid_reg, s1_valid_next;
    ppkbd_stage_t       s1_reg, s1_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_rdata_reg, out_rdata_next;
    logic               out_vdis_reg, out_vdis_next;
    logic               out_led_reg, out_led_next;

    logic               accept;
    logic               s1_advance;
    req_t               req;
    port_sel_t          sel;
    logic               row_in_range;
    logic               wr_row_in_range;
    logic               ram_we;
    logic               ram_re;
    logic [DATA_W-1:0]  ram_q;
    logic [DATA_W-1:0]  s1_rdata;
    logic [DATA_W-1:0]  bit_mask;

    assign req    = req_t'(s_req_type);
    assign sel    = port_sel_t'(s_addr);

    // Handshake: stage 1 moves on when the output register is free or drains
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    assign row_in_range    = ({1'b0, port_a_reg[ROW_W-1:0]} < (ROW_W+1)'(KEY_ROWS));
    assign wr_row_in_range = ({1'b0, s_key_row} < (ROW_W+1)'(KEY_ROWS));

    // Key matrix RAM: write on key row update, read the row port A selects
    assign ram_we = accept && (req == REQ_KEY_ROW) && wr_row_in_range;
    assign ram_re = accept;

    ppkbd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (KEY_ROWS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_key_row[ROW_AW-1:0]),
        .wdata (s_key_bits),
        .re    (ram_re),
        .raddr (port_a_reg[ROW_AW-1:0]),
        .rdata (ram_q)
    );

    // Bit set/reset mask for a control word
    assign bit_mask = DATA_W'(1) << s_wdata[3:1];

    // Apply the request to the port latches and the timer
    always_comb begin
        port_a_next    = port_a_reg;
        port_c_next    = port_c_reg;
        timer_next     = timer_reg;
        key_valid_next = key_valid_reg;
        s1_next        = s1_reg;
        if (accept) begin
            s1_next.rdata    = '0;
            s1_next.key_read = 1'b0;
            s1_next.row_ok   = row_in_range && key_valid_reg[port_a_reg[ROW_AW-1:0]];
            case (req)
                REQ_BUS_READ: begin
                    case (sel)
                        SEL_PORT_A: s1_next.rdata = port_a_reg;
                        SEL_PORT_B: s1_next.key_read = 1'b1;
                        SEL_PORT_C: begin
                            // Timer held in reset reads as zero
                            if (!port_a_reg[7]) begin
                                timer_next = '0;
                            end
                            s1_next.rdata = {!s_vblank_active,
                                             port_a_reg[7] && timer_reg[TIMER_OUT_BIT],
                                             2'b00, port_c_reg[3:0]};
                        end
                        default: s1_next.rdata = ALL_ONES;
                    endcase
                end
                REQ_BUS_WRITE: begin
                    case (sel)
                        SEL_PORT_A: begin
                            if (!(s_wdata[7] && port_a_reg[7])) begin
                                timer_next = '0;
                            end
                            port_a_next = s_wdata;
                        end
                        SEL_PORT_B: ;
                        SEL_PORT_C: port_c_next = s_wdata;
                        default: begin
                            // Mode words are dropped
                            if (!s_wdata[7]) begin
                                if (s_wdata[0]) begin
                                    port_c_next = port_c_reg | bit_mask;
                                end else begin
                                    port_c_next = port_c_reg & ~bit_mask;
                                end
                            end
                        end
                    endcase
                end
                REQ_KEY_ROW: begin
                    if (wr_row_in_range) begin
                        key_valid_next[s_key_row[ROW_AW-1:0]] = 1'b1;
                    end
                end
                default: timer_next = timer_reg + TIMER_W'(1);
            endcase
            s1_next.video_disabled = !port_c_next[0];
            s1_next.green_led      = port_c_next[2];
        end
    end

    // Merge the key row read data into the result
    always_comb begin
        s1_rdata = s1_reg.rdata;
        if (s1_reg.key_read) begin
            s1_rdata = s1_reg.row_ok ? ~ram_q : ALL_ONES;
        end
    end

    // Stage and output register control
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_rdata_next = out_rdata_reg;
        out_vdis_next  = out_vdis_reg;
        out_led_next   = out_led_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s1_advance) begin
            out_valid_next = 1'b1;
            out_rdata_next = s1_rdata;
            out_vdis_next  = s1_reg.video_disabled;
            out_led_next   = s1_reg.green_led;
            s1_valid_next  = 1'b0;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_a_reg    <= '0;
            port_c_reg    <= '0;
            timer_reg     <= '0;
            key_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            port_a_reg    <= port_a_next;
            port_c_reg    <= port_c_next;
            timer_reg     <= timer_next;
            key_valid_reg <= key_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        s1_reg        <= s1_next;
        out_rdata_reg <= out_rdata_next;
        out_vdis_reg  <= out_vdis_next;
        out_led_reg   <= out_led_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_rdata          = out_rdata_reg;
    assign m_video_disabled = out_vdis_reg;
    assign m_green_led      = out_led_reg;

    // A port B read of a missing or unwritten row reads as no key pressed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_reg.key_read && !s1_reg.row_ok |-> s1_rdata == ALL_ONES)
        else $error("key read of absent row not all ones");

    // A port C read with port A bit 7 clear leaves the timer cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req == REQ_BUS_READ) && (sel == SEL_PORT_C) && !port_a_reg[7]
        |=> timer_reg == '0)
        else $error("timer not held in reset on port C read");

    // Input stalls only when both stages hold a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with free stage");

endmodule
